// ----- rtl/core/smm_pkg.sv -----
// Shared constants and types for the sparse matrix multiply block.
package smm_pkg;

  localparam int MAX_DIM = 32;
  localparam int MAX_NNZ = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int NNZ_AW  = $clog2(MAX_NNZ);
  localparam int CNT_W   = NNZ_AW + 1;
  localparam int REG_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ENT_W   = DIM_W + VAL_W;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_A_COLS = 2'd1;
  localparam logic [1:0] CFG_B_ROWS = 2'd2;
  localparam logic [1:0] CFG_B_COLS = 2'd3;

endpackage

// ----- rtl/core/sparse_matrix_multiply.sv -----
// Top level: CSR by CSC sparse matrix row product with entry stores in RAM.
// Sequence: a load or clear word is accepted in IDLE and applied in EXEC. A compute
//   word reads the row entries, then walks the entries of each column, and can wait
//   on a stall on the result side; markers are sent from FINISH.
// Throughput: one input word at a time; the single read port of each entry RAM
//   sets the pace, one stored entry per cycle.
// Reset: synchronous, clears fills, counts, overflow and sets all sizes to 32.
module sparse_matrix_multiply (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [47:0]               s_tdata,  // major_index, minor_index, entry_value
  input  logic [1:0]                s_tuser,  // req_type
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [47:0]               m_tdata,  // out_row, out_col, out_value
  output logic [2:0]                m_tuser,  // row_empty, status
  output logic                      m_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [smm_pkg::REG_W-1:0] cfg_data
);
  import smm_pkg::*;

  typedef enum logic [3:0] {
    IDLE, EXEC, ROW_RD, ROW_DRAIN, COL_START, COL_RD,
    COL_DRAIN1, COL_DRAIN2, COL_DONE, FINISH
  } state_t;

  state_t state;

  // size registers
  logic [REG_W-1:0] a_rows, a_cols, b_rows, b_cols;

  // accepted word
  req_t             req;
  logic [DIM_W-1:0] major, minor;
  logic [VAL_W-1:0] value;

  // row and column directory
  logic [NNZ_AW-1:0] lstart [MAX_DIM];
  logic [CNT_W-1:0]  lcount [MAX_DIM];
  logic [NNZ_AW-1:0] rstart [MAX_DIM];
  logic [CNT_W-1:0]  rcount [MAX_DIM];
  logic [CNT_W-1:0]  lfill, rfill;
  logic              overflow;

  // dense copy of the requested row
  logic [VAL_W-1:0]   rowvec [MAX_DIM];
  logic [MAX_DIM-1:0] rowok;

  // walk control
  logic [CNT_W-1:0] ptr, remain;
  logic [REG_W-1:0] col, ncols;
  logic             lvld, rvld, pvld;
  logic [VAL_W-1:0] prod, sum;
  logic             have_pend;
  logic [DIM_W-1:0] pend_col;
  logic [VAL_W-1:0] pend_val;
  status_t          mk_status;

  // RAM ports
  logic              l_wr, r_wr, l_rd, r_rd;
  logic [ENT_W-1:0]  l_rdata, r_rdata;
  logic [DIM_W-1:0]  lk, rk;
  logic [VAL_W-1:0]  lval, rval, rv;
  logic [DIM_W-1:0]  tidx;
  logic              issue, out_free, emit;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // load a word into the output register this cycle
  assign emit = out_free && ((state == FINISH) ||
                             (state == COL_DONE && sum != '0 && have_pend));

  assign issue = (remain != '0) && (ptr < CNT_W'(MAX_NNZ));
  assign l_rd  = (state == ROW_RD) && issue;
  assign r_rd  = (state == COL_RD) && issue;
  assign l_wr  = (state == EXEC) && (req == REQ_LOAD_A) && ({1'b0, major} < a_rows)
                 && (lfill < CNT_W'(MAX_NNZ));
  assign r_wr  = (state == EXEC) && (req == REQ_LOAD_B) && ({1'b0, major} < b_cols)
                 && (rfill < CNT_W'(MAX_NNZ));

  assign lk   = l_rdata[DIM_W-1:0];
  assign lval = l_rdata[ENT_W-1:DIM_W];
  assign rk   = r_rdata[DIM_W-1:0];
  assign rval = r_rdata[ENT_W-1:DIM_W];
  assign rv   = rowok[rk] ? rowvec[rk] : '0;

  // one directory read address: the column walk or the word's major index
  assign tidx = (state == COL_START) ? col[DIM_W-1:0] : major;

  smm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_left_ram (
    .clk     (clk),
    .wr_en   (l_wr),
    .wr_addr (lfill[NNZ_AW-1:0]),
    .wr_data ({value, minor}),
    .rd_en   (l_rd),
    .rd_addr (ptr[NNZ_AW-1:0]),
    .rd_data (l_rdata)
  );

  smm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_right_ram (
    .clk     (clk),
    .wr_en   (r_wr),
    .wr_addr (rfill[NNZ_AW-1:0]),
    .wr_data ({value, minor}),
    .rd_en   (r_rd),
    .rd_addr (ptr[NNZ_AW-1:0]),
    .rd_data (r_rdata)
  );

  // datapath without reset: payload, directory starts, row copy, product
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      major <= s_tdata[DIM_W-1:0];
      minor <= s_tdata[2*DIM_W-1:DIM_W];
      value <= s_tdata[2*DIM_W+VAL_W-1:2*DIM_W];
    end
    if (l_wr && lcount[major] == '0) begin
      lstart[major] <= lfill[NNZ_AW-1:0];
    end
    if (r_wr && rcount[major] == '0) begin
      rstart[major] <= rfill[NNZ_AW-1:0];
    end
    // accumulate row entries, duplicates add up
    if (lvld && {1'b0, lk} < b_rows) begin
      rowvec[lk] <= (rowok[lk] ? rowvec[lk] : '0) + lval;
    end
    // multiply stage, then accumulate stage
    prod <= 32'(rv * rval);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      a_rows    <= REG_W'(MAX_DIM);
      a_cols    <= REG_W'(MAX_DIM);
      b_rows    <= REG_W'(MAX_DIM);
      b_cols    <= REG_W'(MAX_DIM);
      req       <= REQ_LOAD_A;
      lfill     <= '0;
      rfill     <= '0;
      overflow  <= 1'b0;
      rowok     <= '0;
      lvld      <= 1'b0;
      rvld      <= 1'b0;
      pvld      <= 1'b0;
      have_pend <= 1'b0;
      m_tvalid  <= 1'b0;
      mk_status <= ST_OK;
      for (int i = 0; i < MAX_DIM; i++) begin
        lcount[i] <= '0;
        rcount[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_A_ROWS: a_rows <= cfg_data;
          CFG_A_COLS: a_cols <= cfg_data;
          CFG_B_ROWS: b_rows <= cfg_data;
          CFG_B_COLS: b_cols <= cfg_data;
          default: ;
        endcase
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      lvld <= l_rd;
      rvld <= r_rd;
      pvld <= rvld && ({1'b0, rk} < b_rows);
      if (lvld && {1'b0, lk} < b_rows) begin
        rowok[lk] <= 1'b1;
      end
      if (pvld) begin
        sum <= sum + prod;
      end
      if (l_rd || r_rd) begin
        ptr    <= ptr + 1'b1;
        remain <= remain - 1'b1;
      end

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            req   <= req_t'(s_tuser);
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= IDLE;
          case (req)
            REQ_LOAD_A: begin
              if ({1'b0, major} < a_rows) begin
                if (lfill >= CNT_W'(MAX_NNZ)) begin
                  overflow <= 1'b1;
                end else begin
                  lcount[major] <= lcount[major] + 1'b1;
                  lfill         <= lfill + 1'b1;
                end
              end
            end
            REQ_LOAD_B: begin
              if ({1'b0, major} < b_cols) begin
                if (rfill >= CNT_W'(MAX_NNZ)) begin
                  overflow <= 1'b1;
                end else begin
                  rcount[major] <= rcount[major] + 1'b1;
                  rfill         <= rfill + 1'b1;
                end
              end
            end
            REQ_CLEAR: begin
              lfill    <= '0;
              rfill    <= '0;
              overflow <= 1'b0;
              for (int i = 0; i < MAX_DIM; i++) begin
                lcount[i] <= '0;
                rcount[i] <= '0;
              end
            end
            default: begin
              have_pend <= 1'b0;
              col       <= '0;
              ncols     <= (b_cols > REG_W'(MAX_DIM)) ? REG_W'(MAX_DIM) : b_cols;
              rowok     <= '0;
              ptr       <= {1'b0, lstart[tidx]};
              remain    <= lcount[tidx];
              mk_status <= ST_OK;
              if (a_cols != b_rows) begin
                mk_status <= ST_MISMATCH;
                state     <= FINISH;
              end else if (overflow) begin
                mk_status <= ST_OVERFLOW;
                state     <= FINISH;
              end else if ({1'b0, major} >= a_rows || lcount[tidx] == '0) begin
                state <= FINISH;
              end else begin
                state <= ROW_RD;
              end
            end
          endcase
        end
        ROW_RD: begin
          if (!issue) begin
            state <= ROW_DRAIN;
          end
        end
        ROW_DRAIN: state <= COL_START;
        COL_START: begin
          if (col == ncols) begin
            state <= FINISH;
          end else begin
            ptr    <= {1'b0, rstart[tidx]};
            remain <= rcount[tidx];
            sum    <= '0;
            state  <= COL_RD;
          end
        end
        COL_RD: begin
          if (!issue) begin
            state <= COL_DRAIN1;
          end
        end
        COL_DRAIN1: state <= COL_DRAIN2;
        COL_DRAIN2: state <= COL_DONE;
        COL_DONE: begin
          // hold one nonzero sum back so the final one can carry last
          if (sum == '0) begin
            col   <= col + 1'b1;
            state <= COL_START;
          end else if (!have_pend) begin
            have_pend <= 1'b1;
            pend_col  <= col[DIM_W-1:0];
            pend_val  <= sum;
            col       <= col + 1'b1;
            state     <= COL_START;
          end else if (out_free) begin
            m_tdata  <= {6'd0, pend_val, pend_col, major};
            m_tuser  <= {ST_OK, 1'b0};
            m_tlast  <= 1'b0;
            pend_col <= col[DIM_W-1:0];
            pend_val <= sum;
            col      <= col + 1'b1;
            state    <= COL_START;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            if (have_pend) begin
              m_tdata <= {6'd0, pend_val, pend_col, major};
              m_tuser <= {ST_OK, 1'b0};
            end else begin
              m_tdata <= {6'd0, {VAL_W{1'b0}}, {DIM_W{1'b0}}, major};
              m_tuser <= {mk_status, 1'b1};
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_lfill_bound: assert property (@(posedge clk) disable iff (rst)
    lfill <= CNT_W'(MAX_NNZ)) else $error("left fill past store depth");

  a_rfill_bound: assert property (@(posedge clk) disable iff (rst)
    rfill <= CNT_W'(MAX_NNZ)) else $error("right fill past store depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == EXEC) else $error("accepted word not executed");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast) else $error("empty marker without last");

  a_no_read_overlap: assert property (@(posedge clk) disable iff (rst)
    !(l_rd && r_rd)) else $error("both stores read at once");

endmodule

// ----- rtl/core/smm_ram.sv -----
// Simple dual-port RAM, one write and one registered read port.
module smm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
